FILE: rtl/ppc_pkg.sv
`timescale 1ns / 1ps

package ppc_pkg;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;

	localparam int MAX_DUTY    = 999;
	localparam int GIVE_UP_PWM = 200;
	localparam int FRAC_BITS   = 8;
	localparam int DRIVE_LIM   = MAX_DUTY * (2 ** FRAC_BITS);

	localparam logic [15:0] PROP_GAIN_RST  = 16'd346;
	localparam logic [15:0] INTEG_GAIN_RST = 16'd0;
	localparam logic [15:0] DERIV_GAIN_RST = 16'd384;
	localparam logic [15:0] CPD_RST        = 16'd1408;
	localparam logic [9:0]  MIN_DRIVE_RST  = 10'd190;
	localparam logic [7:0]  STOP_BAND_RST  = 8'd3;
	localparam logic [7:0]  GIVE_UP_RST    = 8'd5;
	localparam logic [7:0]  INTEG_BAND_RST = 8'd10;

	localparam logic [1:0] DIR_FWD  = 2'd0;
	localparam logic [1:0] DIR_REV  = 2'd1;
	localparam logic [1:0] DIR_STOP = 2'd2;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_PROP_GAIN   = 3'd0,
		REG_INTEG_GAIN  = 3'd1,
		REG_DERIV_GAIN  = 3'd2,
		REG_CPD         = 3'd3,
		REG_MIN_DRIVE   = 3'd4,
		REG_STOP_BAND   = 3'd5,
		REG_GIVE_UP     = 3'd6,
		REG_INTEG_BAND  = 3'd7
	} ppc_reg_t;

	typedef enum logic [1:0] {
		MUL_SCALE,
		MUL_PROP,
		MUL_INTEG,
		MUL_DERIV
	} ppc_mul_sel_t;

	typedef struct packed {
		logic signed [23:0] target_degrees;
		logic signed [31:0] encoder_count;
	} ppc_in_t;

	typedef struct packed {
		logic [9:0]         pwm_duty;
		logic [1:0]         direction_status;
		logic               bridge_a;
		logic               bridge_b;
		logic signed [31:0] position_error;
	} ppc_out_t;

	typedef struct packed {
		logic         load;
		logic         mul_en;
		ppc_mul_sel_t mul_sel;
		logic         err_en;
		logic         diff_en;
		logic         p_en;
		logic         integ_en;
		logic         add_d_en;
		logic         add_i_en;
		logic         out_en;
	} ppc_cmd_t;

endpackage

FILE: rtl/ppc_ctrl.sv
`timescale 1ns / 1ps

module ppc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	output ppc_pkg::ppc_cmd_t cmd
);
	import ppc_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCALE,
		S_ERR,
		S_MUL_P,
		S_MUL_I,
		S_MUL_D,
		S_ADD_D,
		S_ADD_I,
		S_DRIVE
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		cmd.mul_sel = MUL_SCALE;
		unique case (state_q)
			S_IDLE: begin
				cmd.load = in_valid;
			end
			S_SCALE: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_SCALE;
			end
			S_ERR: begin
				cmd.err_en = 1'b1;
			end
			S_MUL_P: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_PROP;
				cmd.diff_en = 1'b1;
			end
			S_MUL_I: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_INTEG;
				cmd.p_en    = 1'b1;
			end
			S_MUL_D: begin
				cmd.mul_en   = 1'b1;
				cmd.mul_sel  = MUL_DERIV;
				cmd.integ_en = 1'b1;
			end
			S_ADD_D: begin
				cmd.add_d_en = 1'b1;
			end
			S_ADD_I: begin
				cmd.add_i_en = 1'b1;
			end
			S_DRIVE: begin
				cmd.out_en = out_free;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_DRIVE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE:  if (in_valid) state_q <= S_SCALE;
				S_SCALE: state_q <= S_ERR;
				S_ERR:   state_q <= S_MUL_P;
				S_MUL_P: state_q <= S_MUL_I;
				S_MUL_I: state_q <= S_MUL_D;
				S_MUL_D: state_q <= S_ADD_D;
				S_ADD_D: state_q <= S_ADD_I;
				S_ADD_I: state_q <= S_DRIVE;
				S_DRIVE: if (out_free) state_q <= S_IDLE;
			endcase
		end
	end

endmodule

FILE: rtl/ppc_datapath.sv
`timescale 1ns / 1ps

module ppc_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  ppc_pkg::ppc_cmd_t                   cmd,
	input  ppc_pkg::ppc_in_t                    in_data,
	output ppc_pkg::ppc_out_t                   out_data,
	input  logic                                cfg_we,
	input  logic [ppc_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [ppc_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import ppc_pkg::*;

	// configuration
	logic [15:0] prop_gain_q, integ_gain_q, deriv_gain_q, cpd_q;
	logic [9:0]  min_drive_q;
	logic [7:0]  stop_band_q, give_up_q, integ_band_q;

	// loop state
	logic signed [31:0] prev_q;
	logic signed [47:0] integ_q;
	logic               bridge_a_q, bridge_b_q;
	logic [1:0]         last_dir_q;

	// working registers
	ppc_in_t            in_q;
	logic signed [49:0] prod_q;
	logic signed [31:0] e_q;
	logic [32:0]        ae_q;
	logic signed [32:0] diff_q;
	logic signed [51:0] u_q;
	ppc_out_t           out_q;

	assign out_data = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q  <= PROP_GAIN_RST;
			integ_gain_q <= INTEG_GAIN_RST;
			deriv_gain_q <= DERIV_GAIN_RST;
			cpd_q        <= CPD_RST;
			min_drive_q  <= MIN_DRIVE_RST;
			stop_band_q  <= STOP_BAND_RST;
			give_up_q    <= GIVE_UP_RST;
			integ_band_q <= INTEG_BAND_RST;
		end else if (cfg_we) begin
			unique case (ppc_reg_t'(cfg_index))
				REG_PROP_GAIN:  prop_gain_q  <= cfg_data;
				REG_INTEG_GAIN: integ_gain_q <= cfg_data;
				REG_DERIV_GAIN: deriv_gain_q <= cfg_data;
				REG_CPD:        cpd_q        <= cfg_data;
				REG_MIN_DRIVE:  min_drive_q  <= cfg_data[9:0];
				REG_STOP_BAND:  stop_band_q  <= cfg_data[7:0];
				REG_GIVE_UP:    give_up_q    <= cfg_data[7:0];
				REG_INTEG_BAND: integ_band_q <= cfg_data[7:0];
			endcase
		end
	end

	// shared multiplier
	logic signed [32:0] mul_a;
	logic signed [16:0] mul_b;
	logic signed [49:0] mul_p;

	always_comb begin
		unique case (cmd.mul_sel)
			MUL_SCALE: begin
				mul_a = 33'(in_q.target_degrees);
				mul_b = $signed({1'b0, cpd_q});
			end
			MUL_PROP: begin
				mul_a = 33'(e_q);
				mul_b = $signed({1'b0, prop_gain_q});
			end
			MUL_INTEG: begin
				mul_a = 33'(e_q);
				mul_b = $signed({1'b0, integ_gain_q});
			end
			MUL_DERIV: begin
				mul_a = diff_q;
				mul_b = $signed({1'b0, deriv_gain_q});
			end
		endcase
		mul_p = 50'(mul_a) * 50'(mul_b);
	end

	// error from scaled target, truncated toward zero
	logic signed [39:0] scaled;
	logic signed [40:0] rnd;
	logic signed [32:0] setp;
	logic signed [33:0] err_full;
	logic signed [31:0] e_next;
	logic [32:0]        ae_next;

	always_comb begin
		scaled   = prod_q[39:0];
		rnd      = 41'(scaled) + (scaled[39] ? 41'sd255 : 41'sd0);
		setp     = rnd[40:8];
		err_full = 34'(setp) - 34'(in_q.encoder_count);
		if (err_full[33:31] == 3'b000 || err_full[33:31] == 3'b111) begin
			e_next = err_full[31:0];
		end else if (err_full[33]) begin
			e_next = 32'sh8000_0000;
		end else begin
			e_next = 32'sh7fff_ffff;
		end
		if (e_next[31]) begin
			ae_next = 33'(-33'(e_next));
		end else begin
			ae_next = {1'b0, e_next};
		end
	end

	// integral with saturation
	logic signed [48:0] isum;
	logic signed [47:0] isat;
	logic               in_band;

	always_comb begin
		isum    = 49'(integ_q) + 49'($signed(prod_q[47:0]));
		in_band = (ae_q < {25'd0, integ_band_q});
		if (isum[48] != isum[47]) begin
			isat = isum[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
		end else begin
			isat = isum[47:0];
		end
	end

	// drive, clamp and decision
	logic               u_pos, u_neg;
	logic signed [52:0] drive, drive_c;
	logic [17:0]        drive_mag;
	logic [9:0]         pwm;
	logic               a_n, b_n;
	logic [1:0]         dir_n;
	logic signed [52:0] lim;

	always_comb begin
		lim   = 53'(DRIVE_LIM);
		u_pos = !u_q[51] && (u_q != '0);
		u_neg = u_q[51];
		drive = 53'(u_q);
		a_n   = bridge_a_q;
		b_n   = bridge_b_q;
		dir_n = last_dir_q;
		if (u_pos) begin
			drive = drive + 53'({min_drive_q, 8'd0});
			a_n   = 1'b1;
			b_n   = 1'b0;
			dir_n = DIR_FWD;
		end else if (u_neg) begin
			drive = drive - 53'({min_drive_q, 8'd0});
			a_n   = 1'b0;
			b_n   = 1'b1;
			dir_n = DIR_REV;
		end
		if (drive > lim) begin
			drive_c = lim;
		end else if (drive < -lim) begin
			drive_c = -lim;
		end else begin
			drive_c = drive;
		end
		drive_mag = drive_c[52] ? 18'(-drive_c) : drive_c[17:0];
		pwm       = drive_mag[17:8];
		if (ae_q <= {25'd0, stop_band_q}) begin
			a_n   = 1'b0;
			b_n   = 1'b0;
			pwm   = '0;
			dir_n = DIR_STOP;
		end
		if (ae_q <= {25'd0, give_up_q} && pwm <= 10'(GIVE_UP_PWM)) begin
			pwm   = '0;
			dir_n = DIR_STOP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q     <= '0;
			integ_q    <= '0;
			bridge_a_q <= 1'b0;
			bridge_b_q <= 1'b0;
			last_dir_q <= DIR_FWD;
		end else begin
			if (cmd.diff_en) begin
				prev_q <= e_q;
			end
			if (cmd.integ_en && in_band) begin
				integ_q <= isat;
			end
			if (cmd.out_en) begin
				bridge_a_q <= a_n;
				bridge_b_q <= b_n;
				last_dir_q <= dir_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			in_q <= in_data;
		end
		if (cmd.mul_en) begin
			prod_q <= mul_p;
		end
		if (cmd.err_en) begin
			e_q  <= e_next;
			ae_q <= ae_next;
		end
		if (cmd.diff_en) begin
			diff_q <= 33'(e_q) - 33'(prev_q);
		end
		if (cmd.p_en) begin
			u_q <= 52'(prod_q);
		end else if (cmd.add_d_en) begin
			u_q <= u_q + 52'(prod_q);
		end else if (cmd.add_i_en) begin
			u_q <= u_q + 52'(integ_q);
		end
		if (cmd.out_en) begin
			out_q.pwm_duty         <= pwm;
			out_q.direction_status <= dir_n;
			out_q.bridge_a         <= a_n;
			out_q.bridge_b         <= b_n;
			out_q.position_error   <= e_q;
		end
	end

endmodule

FILE: rtl/pid_position_controller.sv
`timescale 1ns / 1ps

// position pid loop for a dc motor on an h-bridge. each input transfer carries a target
// angle and an encoder count and yields one result transfer with pwm duty, direction,
// bridge levels and the saturated position error. a sequencer walks one shared 33x17
// multiplier through the scale, p, i and d products; a new item is taken once the
// previous one has left the datapath, while its result may still wait in the output
// register. configuration writes are always ready and take effect at once.

module pid_position_controller (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  ppc_pkg::ppc_in_t                    in_data,
	output logic                                out_valid,
	input  logic                                out_stall,
	output ppc_pkg::ppc_out_t                   out_data,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [ppc_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [ppc_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import ppc_pkg::*;

	ppc_cmd_t cmd;

	assign cfg_ready = 1'b1;

	ppc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	ppc_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_data   (in_data),
		.out_data  (out_data),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

endmodule

FILE: test/pid_result_checker.sv
`timescale 1ns / 1ps

module pid_result_checker
	import ppc_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic                   in_stall,
	input  ppc_in_t                in_data,
	input  logic                   out_valid,
	input  logic                   out_stall,
	input  ppc_out_t               out_data,
	input  logic                   cfg_valid,
	input  logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output int                     fail_count,
	output int                     pending
);

	localparam longint ERR_MAX   = 64'sd2147483647;
	localparam longint ERR_MIN   = -64'sd2147483648;
	localparam longint INTEG_MAX = (64'sd1 <<< 47) - 1;
	localparam longint INTEG_MIN = -(64'sd1 <<< 47);

	longint kp, ki, kd, cpd, min_drv, stop_bd, giveup_bd, integ_bd;
	longint prev_err, integ_acc;
	logic br_a, br_b;
	logic [1:0] last_dir;

	ppc_out_t expected_drive_q[$];
	ppc_out_t want;

	function automatic ppc_out_t predict_drive(ppc_in_t item);
		longint tgt, meas, setp, e, ae, u, drv, pwm;
		ppc_out_t res;
		tgt = $signed(item.target_degrees);
		meas = $signed(item.encoder_count);
		// scale to counts, division truncates toward zero
		setp = (tgt * cpd) / 256;
		e = setp - meas;
		if (e > ERR_MAX) e = ERR_MAX;
		if (e < ERR_MIN) e = ERR_MIN;
		ae = (e < 0) ? -e : e;
		if (ae < integ_bd) begin
			integ_acc = integ_acc + ki * e;
			if (integ_acc > INTEG_MAX) integ_acc = INTEG_MAX;
			if (integ_acc < INTEG_MIN) integ_acc = INTEG_MIN;
		end
		u = kp * e + integ_acc + kd * (e - prev_err);
		drv = u;
		if (u > 0) begin
			drv = drv + min_drv * 256;
			br_a = 1'b1;
			br_b = 1'b0;
			last_dir = DIR_FWD;
		end else if (u < 0) begin
			drv = drv - min_drv * 256;
			br_a = 1'b0;
			br_b = 1'b1;
			last_dir = DIR_REV;
		end
		// clamp after the offset
		if (drv > longint'(DRIVE_LIM)) drv = DRIVE_LIM;
		if (drv < -longint'(DRIVE_LIM)) drv = -longint'(DRIVE_LIM);
		pwm = ((drv < 0) ? -drv : drv) / 256;
		if (ae <= stop_bd) begin
			br_a = 1'b0;
			br_b = 1'b0;
			pwm = 0;
			last_dir = DIR_STOP;
		end
		if (ae <= giveup_bd && pwm <= GIVE_UP_PWM) begin
			pwm = 0;
			last_dir = DIR_STOP;
		end
		prev_err = e;
		res.pwm_duty = pwm[9:0];
		res.direction_status = last_dir;
		res.bridge_a = br_a;
		res.bridge_b = br_b;
		res.position_error = e[31:0];
		return res;
	endfunction

	function automatic void check_field(string name, longint want_v, longint got_v);
		if (want_v != got_v) begin
			$error("%s: expected %0d, actual %0d", name, want_v, got_v);
			fail_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp = PROP_GAIN_RST;
			ki = INTEG_GAIN_RST;
			kd = DERIV_GAIN_RST;
			cpd = CPD_RST;
			min_drv = MIN_DRIVE_RST;
			stop_bd = STOP_BAND_RST;
			giveup_bd = GIVE_UP_RST;
			integ_bd = INTEG_BAND_RST;
			prev_err = 0;
			integ_acc = 0;
			br_a = 1'b0;
			br_b = 1'b0;
			last_dir = DIR_FWD;
			expected_drive_q.delete();
			fail_count = 0;
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_PROP_GAIN:  kp = cfg_data;
					REG_INTEG_GAIN: ki = cfg_data;
					REG_DERIV_GAIN: kd = cfg_data;
					REG_CPD:        cpd = cfg_data;
					REG_MIN_DRIVE:  min_drv = cfg_data[9:0];
					REG_STOP_BAND:  stop_bd = cfg_data[7:0];
					REG_GIVE_UP:    giveup_bd = cfg_data[7:0];
					REG_INTEG_BAND: integ_bd = cfg_data[7:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				expected_drive_q.push_back(predict_drive(in_data));
			if (out_valid && !out_stall) begin
				if (expected_drive_q.size() == 0) begin
					$error("result transfer with no expectation waiting");
					fail_count++;
				end else begin
					want = expected_drive_q.pop_front();
					check_field("pwm_duty", want.pwm_duty, out_data.pwm_duty);
					check_field("direction_status", want.direction_status,
						out_data.direction_status);
					check_field("bridge_a", want.bridge_a, out_data.bridge_a);
					check_field("bridge_b", want.bridge_b, out_data.bridge_b);
					check_field("position_error", $signed(want.position_error),
						$signed(out_data.position_error));
				end
			end
			pending <= expected_drive_q.size();
		end
	end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import ppc_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int PHASES = 12;
	localparam int ITEMS_PER_PHASE = 88;
	localparam longint CNT_MAX = 64'sd2147483647;
	localparam longint CNT_MIN = -64'sd2147483648;

	typedef struct {
		logic [15:0] kp;
		logic [15:0] ki;
		logic [15:0] kd;
		logic [15:0] cpd;
		logic [15:0] min_drive;
		logic [15:0] stop_band;
		logic [15:0] give_up_band;
		logic [15:0] integ_band;
	} gain_set_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	ppc_in_t in_data;
	logic out_valid;
	logic out_stall;
	ppc_out_t out_data;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int fail_count;
	int pending;
	int send_pct;
	int stall_pct;
	logic [15:0] cpd_now;

	pid_position_controller i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	pid_result_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("TEST FAILED");
		$finish;
	end

	task automatic send_item(ppc_in_t item);
		while ($urandom_range(99) < send_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= item;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic send_pair(int tgt, int meas);
		ppc_in_t item;
		item.target_degrees = tgt[23:0];
		item.encoder_count = meas;
		send_item(item);
	endtask

	task automatic write_reg(ppc_reg_t idx, logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic load_settings(gain_set_t s);
		write_reg(REG_PROP_GAIN, s.kp);
		write_reg(REG_INTEG_GAIN, s.ki);
		write_reg(REG_DERIV_GAIN, s.kd);
		write_reg(REG_CPD, s.cpd);
		write_reg(REG_MIN_DRIVE, s.min_drive);
		write_reg(REG_STOP_BAND, s.stop_band);
		write_reg(REG_GIVE_UP, s.give_up_band);
		write_reg(REG_INTEG_BAND, s.integ_band);
		cfg_valid <= 1'b0;
		cpd_now = s.cpd;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	function automatic logic [15:0] pick_gain();
		return ($urandom_range(1) != 0) ? 16'($urandom_range(1023)) : 16'($urandom);
	endfunction

	function automatic gain_set_t random_settings();
		gain_set_t s;
		s.kp = pick_gain();
		s.ki = pick_gain();
		s.kd = pick_gain();
		s.cpd = ($urandom_range(1) != 0) ? 16'($urandom_range(4096)) : 16'($urandom);
		// upper bits beyond the register width are junk on purpose
		s.min_drive = ($urandom_range(1) != 0) ? 16'($urandom_range(300)) : 16'($urandom);
		s.stop_band = ($urandom_range(1) != 0) ? 16'($urandom_range(12)) : 16'($urandom);
		s.give_up_band = ($urandom_range(1) != 0) ? 16'($urandom_range(20)) : 16'($urandom);
		s.integ_band = ($urandom_range(1) != 0) ? 16'($urandom_range(40)) : 16'($urandom);
		return s;
	endfunction

	function automatic ppc_in_t make_item();
		ppc_in_t item;
		longint tgt, setp, delta, meas;
		int unsigned pick;
		pick = $urandom_range(99);
		item.target_degrees = 24'($urandom);
		item.encoder_count = $urandom;
		if (pick < 62) begin
			// measured position close to the scaled target
			if ($urandom_range(9) < 7)
				item.target_degrees = 24'($urandom_range(4000)) - 24'd2000;
			tgt = $signed(item.target_degrees);
			setp = (tgt * longint'(cpd_now)) / 256;
			case ($urandom_range(3))
				0: delta = longint'($urandom_range(40)) - 20;
				1, 2: delta = longint'($urandom_range(600)) - 300;
				default: delta = longint'($urandom_range(6000)) - 3000;
			endcase
			meas = setp - delta;
			if (meas > CNT_MAX) meas = CNT_MAX;
			if (meas < CNT_MIN) meas = CNT_MIN;
			item.encoder_count = meas[31:0];
		end else if (pick >= 82) begin
			case ($urandom_range(4))
				0: item.target_degrees = 24'h7F_FFFF;
				1: item.target_degrees = 24'h80_0000;
				2: item.target_degrees = 24'h00_0000;
				3: item.target_degrees = 24'hFF_FFFF;
				default: item.target_degrees = 24'h00_0001;
			endcase
			case ($urandom_range(4))
				0: item.encoder_count = 32'h7FFF_FFFF;
				1: item.encoder_count = 32'h8000_0000;
				2: item.encoder_count = 32'h0000_0000;
				3: item.encoder_count = 32'hFFFF_FFFF;
				default: item.encoder_count = 32'h0000_0001;
			endcase
		end
		return item;
	endfunction

	initial begin
		gain_set_t s;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		in_data <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_PROP_GAIN;
		cfg_data <= '0;
		send_pct = 0;
		stall_pct = 0;
		cpd_now = CPD_RST;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// stop and give-up band edges, truncation of the scaled target, error saturation
		send_pair(0, 0);
		send_pair(0, 3);
		send_pair(0, -3);
		send_pair(0, 4);
		send_pair(0, -5);
		send_pair(0, 6);
		send_pair(0, -6);
		send_pair(1, 0);
		send_pair(-1, 0);
		send_pair(100, 0);
		send_pair(-100, 0);
		send_pair(0, 9);
		send_pair(0, -9);
		send_pair(0, 2);
		send_pair(32'h007F_FFFF, 32'h8000_0000);
		send_pair(32'hFF80_0000, 32'h7FFF_FFFF);
		send_pair(0, 32'h7FFF_FFFF);
		send_pair(0, 32'h8000_0000);
		send_pair(10, 50);
		send_pair(10, 56);
		drain();

		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: s = '{PROP_GAIN_RST, INTEG_GAIN_RST, DERIV_GAIN_RST, CPD_RST,
					16'(MIN_DRIVE_RST), 16'(STOP_BAND_RST), 16'(GIVE_UP_RST),
					16'(INTEG_BAND_RST)};
				1: s = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
					16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
				2: s = '{16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0};
				default: s = random_settings();
			endcase
			load_settings(s);
			case (phase % 4)
				0: begin send_pct = 0;  stall_pct = 0;  end
				1: begin send_pct = 81; stall_pct = 0;  end
				2: begin send_pct = 0;  stall_pct = 81; end
				default: begin send_pct = 28; stall_pct = 28; end
			endcase
			repeat (ITEMS_PER_PHASE) send_item(make_item());
			drain();
		end

		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
